@@ hw/rtl/expiring_entry_table_macros.svh @@
// Assertion macros used by the top level of the expiring entry table.
`ifndef EXPIRING_ENTRY_TABLE_MACROS_SVH
`define EXPIRING_ENTRY_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EET_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define EET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/eet_pkg.sv @@
// Types, constants and codes of the expiring entry table.
package eet_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam logic [7:0] HOLD_MAX = 8'd255;
    localparam logic [3:0] LOCK_KIND_RESET = 4'd4;

    localparam logic [1:0] RESP_RECEIPT = 2'd0;
    localparam logic [1:0] RESP_REPORT = 2'd1;
    localparam logic [1:0] RESP_ADVANCE = 2'd2;

    localparam logic REQ_INSERT = 1'b0;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  kind;
        logic [1:0]  owner;
        logic [7:0]  action_index;
        logic [15:0] hold_ticks;
        logic [31:0] tick;
    } eet_req_t;

    typedef struct packed {
        logic [1:0] resp_kind;
        logic       accepted;
        logic       replaced;
        logic [3:0] slot;
        logic [1:0] expired_owner;
        logic [7:0] expired_action;
        logic       last;
    } eet_rsp_t;

    typedef struct packed {
        logic [3:0] lock_kind;
    } eet_cfg_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  owner;
        logic [7:0]  action;
        logic [7:0]  remain;
        logic [31:0] src_tick;
        logic [31:0] serial;
    } eet_entry_t;

    typedef enum logic [2:0] {
        EMIT_INS_REJECT,
        EMIT_RECEIPT,
        EMIT_REPORT,
        EMIT_ADV_REJECT,
        EMIT_ADV_DONE
    } eet_emit_t;

    typedef enum logic [0:0] {
        RD_IDX,
        RD_LAST
    } eet_rd_sel_t;

    typedef enum logic [1:0] {
        SLOT_IDX,
        SLOT_COUNT,
        SLOT_BEST
    } eet_slot_sel_t;

    typedef struct packed {
        logic          capture;
        logic          idx_clear;
        logic          idx_inc;
        logic          rd_en;
        eet_rd_sel_t   rd_sel;
        logic          scan_min;
        logic          wr_insert;
        eet_slot_sel_t slot_sel;
        logic          wr_dec;
        logic          wr_move;
        logic          set_last_tick;
        logic          emit;
        eet_emit_t     emit_code;
    } eet_cmd_t;

    typedef struct packed {
        logic is_insert;
        logic kind_zero;
        logic is_lock;
        logic tick_rep;
        logic idx_lt_count;
        logic count_full;
        logic match;
        logic older;
        logic expire;
        logic rd_lock;
    } eet_status_t;

endpackage

@@ hw/rtl/eet_chan.sv @@
// Valid/ready channel interface carrying one payload item.
interface eet_chan #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/eet_ctrl.sv @@
// Controller state machine of the expiring entry table.
module eet_ctrl
    import eet_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    input  eet_status_t status,
    output eet_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LK_RD,
        S_LK_EV,
        S_APPEND,
        S_MN_RD,
        S_MN_EV,
        S_AD_RD,
        S_AD_EV,
        S_AD_REP,
        S_AD_MVRD,
        S_AD_MV,
        S_FIN
    } state_t;

    state_t    state_reg, state_next;
    logic      out_valid_reg, out_valid_next;
    eet_emit_t fin_code_reg, fin_code_next;
    logic      out_free;

    assign out_free = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        fin_code_next = fin_code_reg;
        cmd = '0;
        cmd.rd_sel = RD_IDX;
        cmd.slot_sel = SLOT_IDX;
        cmd.emit_code = fin_code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.idx_clear = 1'b1;
                if (status.is_insert)
                begin
                    if (status.kind_zero)
                    begin
                        fin_code_next = EMIT_INS_REJECT;
                        state_next = S_FIN;
                    end
                    else if (status.is_lock)
                        state_next = S_LK_RD;
                    else
                        state_next = S_APPEND;
                end
                else if (status.tick_rep)
                begin
                    fin_code_next = EMIT_ADV_REJECT;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.set_last_tick = 1'b1;
                    state_next = S_AD_RD;
                end
            end
            S_LK_RD:
            begin
                if (status.idx_lt_count)
                begin
                    cmd.rd_en = 1'b1;
                    state_next = S_LK_EV;
                end
                else
                    state_next = S_APPEND;
            end
            S_LK_EV:
            begin
                if (status.match)
                begin
                    cmd.wr_insert = 1'b1;
                    cmd.slot_sel = SLOT_IDX;
                    fin_code_next = EMIT_RECEIPT;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = S_LK_RD;
                end
            end
            S_APPEND:
            begin
                if (status.count_full)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next = S_MN_RD;
                end
                else
                begin
                    cmd.wr_insert = 1'b1;
                    cmd.slot_sel = SLOT_COUNT;
                    fin_code_next = EMIT_RECEIPT;
                    state_next = S_FIN;
                end
            end
            S_MN_RD:
            begin
                if (status.idx_lt_count)
                begin
                    cmd.rd_en = 1'b1;
                    state_next = S_MN_EV;
                end
                else
                begin
                    cmd.wr_insert = 1'b1;
                    cmd.slot_sel = SLOT_BEST;
                    fin_code_next = EMIT_RECEIPT;
                    state_next = S_FIN;
                end
            end
            S_MN_EV:
            begin
                cmd.scan_min = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next = S_MN_RD;
            end
            S_AD_RD:
            begin
                if (status.idx_lt_count)
                begin
                    cmd.rd_en = 1'b1;
                    state_next = S_AD_EV;
                end
                else
                begin
                    fin_code_next = EMIT_ADV_DONE;
                    state_next = S_FIN;
                end
            end
            S_AD_EV:
            begin
                if (!status.older)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = S_AD_RD;
                end
                else if (!status.expire)
                begin
                    cmd.wr_dec = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next = S_AD_RD;
                end
                else if (status.rd_lock)
                    state_next = S_AD_REP;
                else
                    state_next = S_AD_MVRD;
            end
            S_AD_REP:
            begin
                if (out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_code = EMIT_REPORT;
                    state_next = S_AD_MVRD;
                end
            end
            S_AD_MVRD:
            begin
                // Fetch the last occupied entry to fill the freed slot.
                cmd.rd_en = 1'b1;
                cmd.rd_sel = RD_LAST;
                state_next = S_AD_MV;
            end
            S_AD_MV:
            begin
                // The index stays put so the moved entry is examined next.
                cmd.wr_move = 1'b1;
                state_next = S_AD_RD;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !rsp_ready) || cmd.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            fin_code_reg <= EMIT_INS_REJECT;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            fin_code_reg <= fin_code_next;
        end
    end

endmodule

@@ hw/rtl/eet_dp.sv @@
// Datapath of the expiring entry table: entry memory, counters and result register.
module eet_dp
    import eet_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  eet_cmd_t    cmd,
    output eet_status_t status,
    input  eet_req_t    req_data,
    input  logic        cfg_valid,
    input  eet_cfg_t    cfg_data,
    output eet_rsp_t    rsp_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    eet_entry_t mem [CAPACITY];
    eet_entry_t rd_reg;

    eet_req_t        req_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   best_reg;
    logic [31:0]     best_serial_reg;
    logic [31:0]     serial_reg;
    logic [31:0]     last_tick_reg;
    logic [3:0]      lock_kind_reg;
    logic [IW-1:0]   slot_reg;
    logic            rep_reg;
    eet_rsp_t        rsp_reg, rsp_next;

    logic [CW-1:0]   count_m1;
    logic [IW-1:0]   raddr;
    logic            mem_we;
    logic [IW-1:0]   waddr;
    eet_entry_t      wdata;
    eet_entry_t      new_entry;
    logic [IW-1:0]   ins_slot;
    logic [CW-1:0]   count_after;
    logic            ins_rep;
    logic [7:0]      slot_ext;

    assign count_m1 = count_reg - CW'(1);
    assign raddr = (cmd.rd_sel == RD_LAST) ? count_m1[IW-1:0] : idx_reg[IW-1:0];

    assign status.is_insert = (req_reg.req_type == REQ_INSERT);
    assign status.kind_zero = (req_reg.kind == 4'd0);
    assign status.is_lock = (req_reg.kind == lock_kind_reg);
    assign status.tick_rep = (req_reg.tick == last_tick_reg);
    assign status.idx_lt_count = (idx_reg < count_reg);
    assign status.count_full = (count_reg == CW'(CAPACITY));
    assign status.match = (rd_reg.kind == req_reg.kind) && (rd_reg.owner == req_reg.owner);
    assign status.older = (rd_reg.src_tick < req_reg.tick);
    assign status.expire = status.older && (rd_reg.remain <= 8'd1);
    assign status.rd_lock = (rd_reg.kind == lock_kind_reg);

    always_comb
    begin
        new_entry.kind = req_reg.kind;
        new_entry.owner = req_reg.owner;
        new_entry.action = req_reg.action_index;
        new_entry.remain = (req_reg.hold_ticks > 16'(HOLD_MAX)) ? HOLD_MAX
                                                               : req_reg.hold_ticks[7:0];
        new_entry.src_tick = req_reg.tick;
        new_entry.serial = serial_reg + 32'd1;

        case (cmd.slot_sel)
            SLOT_COUNT: ins_slot = count_reg[IW-1:0];
            SLOT_BEST:  ins_slot = best_reg;
            default:    ins_slot = idx_reg[IW-1:0];
        endcase
        count_after = (cmd.slot_sel == SLOT_COUNT) ? count_reg + CW'(1) : count_reg;
        ins_rep = (CW'(ins_slot) + CW'(1)) < count_after;

        mem_we = cmd.wr_insert || cmd.wr_dec || cmd.wr_move;
        waddr = cmd.wr_insert ? ins_slot : idx_reg[IW-1:0];
        wdata = rd_reg;
        if (cmd.wr_insert)
            wdata = new_entry;
        else if (cmd.wr_dec)
            wdata.remain = rd_reg.remain - 8'd1;

        count_next = count_reg;
        if (cmd.wr_insert && cmd.slot_sel == SLOT_COUNT)
            count_next = count_reg + CW'(1);
        else if (cmd.wr_move)
            count_next = count_m1;

        idx_next = idx_reg;
        if (cmd.idx_clear)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + CW'(1);

        rsp_next = '0;
        case (cmd.emit_code)
            EMIT_RECEIPT:
            begin
                rsp_next.resp_kind = RESP_RECEIPT;
                rsp_next.accepted = 1'b1;
                rsp_next.replaced = rep_reg;
                rsp_next.slot = slot_ext[3:0];
                rsp_next.last = 1'b1;
            end
            EMIT_REPORT:
            begin
                rsp_next.resp_kind = RESP_REPORT;
                rsp_next.accepted = 1'b1;
                rsp_next.expired_owner = rd_reg.owner;
                rsp_next.expired_action = rd_reg.action;
            end
            EMIT_ADV_REJECT:
            begin
                rsp_next.resp_kind = RESP_ADVANCE;
                rsp_next.last = 1'b1;
            end
            EMIT_ADV_DONE:
            begin
                rsp_next.resp_kind = RESP_ADVANCE;
                rsp_next.accepted = 1'b1;
                rsp_next.last = 1'b1;
            end
            default:
            begin
                rsp_next.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (cmd.rd_en)
            rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= req_data;
        if (cmd.wr_insert)
        begin
            slot_reg <= ins_slot;
            rep_reg <= ins_rep;
        end
        if (cmd.emit)
            rsp_reg <= rsp_next;
    end

    assign slot_ext = 8'(slot_reg);
    assign rsp_data = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg <= '0;
            best_reg <= '0;
            best_serial_reg <= '0;
            serial_reg <= '0;
            last_tick_reg <= '0;
            lock_kind_reg <= LOCK_KIND_RESET;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg <= idx_next;
            // The first entry seeds the minimum; later ones replace it only when strictly older.
            if (cmd.scan_min && (idx_reg == '0 || rd_reg.serial < best_serial_reg))
            begin
                best_reg <= idx_reg[IW-1:0];
                best_serial_reg <= rd_reg.serial;
            end
            if (cmd.wr_insert)
                serial_reg <= new_entry.serial;
            if (cmd.set_last_tick)
                last_tick_reg <= req_reg.tick;
            if (cfg_valid)
                lock_kind_reg <= cfg_data.lock_kind;
        end
    end

endmodule

@@ hw/rtl/expiring_entry_table.sv @@
// Top level of the expiring entry table: controller, datapath and checks.
//
//  channel  role    payload
//  req      sink    req_type, kind, owner, action_index, hold_ticks, tick
//  rsp      source  resp_kind, accepted, replaced, slot, expired_owner,
//                   expired_action, last
//  cfg      sink    lock_kind
//
// One request is in work at a time; a table scan reads each entry, then evaluates it.
// A rejected request or an append goes straight to its response; a lock insert first
// scans for an entry of the same kind and owner, an insert into a full table scans for
// the oldest entry, and an advance reports expired lock entries and refills freed slots.
// Reset clears the count, serial counter and last tick; entries need no clear.
// A stalled rsp holds the controller only where it must emit another item.
module expiring_entry_table
    import eet_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input logic   clk,
    input logic   rst_n,
    eet_chan.sink   req,
    eet_chan.source rsp,
    eet_chan.sink   cfg
);

`include "expiring_entry_table_macros.svh"

    eet_cmd_t    cmd;
    eet_status_t status;

    assign cfg.ready = 1'b1;

    eet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    eet_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_data  (req.data),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data),
        .rsp_data  (rsp.data)
    );

    `EET_ASSERT_IMPL(a_one_write, clk, rst_n, cmd.wr_insert, !cmd.wr_dec && !cmd.wr_move)
    `EET_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.emit, !rsp.valid || rsp.ready)
    `EET_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req.valid && req.ready, !req.ready)

endmodule
